@@ src/tcst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tcst_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_ALIVE = 2'd1,
    ACT_END   = 2'd2,
    ACT_FRAME = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_ADDED   = 2'd0,
    EV_UPDATED = 2'd1,
    EV_REMOVED = 2'd2
  } event_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_SCAN,
    S_SET_UPD,
    S_NEAR,
    S_FREE_DEL,
    S_ADD,
    S_AL_ADD,
    S_AL_SCAN,
    S_AL_CMP,
    S_END_NEXT,
    S_END_FIND,
    S_END_REM,
    S_HI_SCAN,
    S_PRUNE,
    S_END_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] sid;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ac;
  } cmd_t;

  typedef struct packed {
    event_e      ev;
    logic [31:0] sess;
    logic [3:0]  fin;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ac;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

@@ src/tcst_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tcst_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);

  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  logic [W-1:0]  mem_q [D];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(D));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/tcst_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tcst_front
  import tcst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        session_id_i,
  input  wire logic signed [31:0] frame_number_i,
  input  wire logic [15:0]        pos_x_i,
  input  wire logic [15:0]        pos_y_i,
  input  wire logic signed [15:0] speed_x_i,
  input  wire logic signed [15:0] speed_y_i,
  input  wire logic signed [15:0] accel_i,
  input  wire logic               cmd_full_i,
  output logic                    cmd_push_o,
  output cmd_t                    cmd_o
);

  logic signed [31:0] cur_frame_q, cur_frame_d;
  logic signed [31:0] prev_frame_q, prev_frame_d;
  logic               accept, stale;

  assign accept = push_i && !cmd_full_i;
  // Drop set, alive and end requests while the current frame runs behind
  assign stale  = (cur_frame_q < prev_frame_q) && (cur_frame_q > 0);

  always_comb begin
    cur_frame_d  = cur_frame_q;
    prev_frame_d = prev_frame_q;
    cmd_push_o   = 1'b0;
    cmd_o.action = action_e'(action_i);
    cmd_o.sid    = session_id_i;
    cmd_o.x      = pos_x_i;
    cmd_o.y      = pos_y_i;
    cmd_o.sx     = speed_x_i;
    cmd_o.sy     = speed_y_i;
    cmd_o.ac     = accel_i;
    if (accept) begin
      if (action_e'(action_i) == ACT_FRAME) begin
        if (cur_frame_q > 0) begin
          prev_frame_d = cur_frame_q;
        end
        cur_frame_d = frame_number_i;
      end else if (!stale) begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_frame_q  <= -32'sd1;
      prev_frame_q <= -32'sd1;
    end else begin
      cur_frame_q  <= cur_frame_d;
      prev_frame_q <= prev_frame_d;
    end
  end

endmodule
`default_nettype wire

@@ src/tcst_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tcst_back
  import tcst_pkg::*;
#(
  parameter int unsigned MAX_CURSORS = 16,
  parameter int unsigned MAX_ALIVE   = 32,
  parameter int unsigned MAX_FREE    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_empty_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int unsigned FW  = $clog2(MAX_CURSORS);
  localparam int unsigned HW  = FW + 1;
  localparam int unsigned FIW = $clog2(MAX_FREE);
  localparam int unsigned FCW = $clog2(MAX_FREE + 1);
  localparam int unsigned AIW = $clog2(MAX_ALIVE);
  localparam int unsigned ACW = $clog2(MAX_ALIVE + 1);
  localparam int unsigned ALD = 2 * (2 ** AIW);

  // Cursor table
  logic              cv_q [MAX_CURSORS];
  logic [31:0]       cs_q [MAX_CURSORS];
  logic [FW-1:0]     cf_q [MAX_CURSORS];
  logic [63:0]       cm_q [MAX_CURSORS];
  logic [15:0]       ca_q [MAX_CURSORS];
  // Free finger list
  logic [FW-1:0]     fe_fin_q [MAX_FREE];
  logic [15:0]       fe_x_q   [MAX_FREE];
  logic [15:0]       fe_y_q   [MAX_FREE];
  // Alive id lists, two banks
  logic [31:0]       al_mem [ALD];
  logic [ALD-1:0]    live_q, live_d;
  logic [31:0]       al_rd_q;
  logic [ACW-1:0]    acnt_q [2];
  logic [ACW-1:0]    acnt_d [2];

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [FW-1:0]     ci_q, ci_d;
  logic [FW:0]       cnt_q, cnt_d;
  logic [FW-1:0]     slot_q, slot_d;
  logic              slot_ok_q, slot_ok_d;
  logic [FW-1:0]     fid_q, fid_d;
  logic signed [HW-1:0] high_q, high_d, nhigh_q, nhigh_d;
  logic [FCW-1:0]    fr_q, fr_d, wi_q, wi_d, fcnt_q, fcnt_d;
  logic [FIW-1:0]    best_q, best_d;
  logic [32:0]       bestd_q, bestd_d;
  logic [FW-1:0]     bestfin_q, bestfin_d;
  logic              bank_q, bank_d;
  logic [ACW-1:0]    ai_q, ai_d;
  logic              pend_v_q, pend_v_d;
  res_t              pend_q, pend_d;
  logic [NRES_W-1:0] nres_q, nres_d;

  // Array write controls
  logic              cur_add, cur_upd, cur_clr;
  logic              fe_wr;
  logic [FIW-1:0]    fe_wa;
  logic [FW-1:0]     fe_wfin;
  logic [15:0]       fe_wx, fe_wy;
  logic              al_wr, al_rd_en;
  logic [AIW:0]      al_wa, al_ra;

  // Read ports
  logic              r_v;
  logic [31:0]       r_s;
  logic [FW-1:0]     r_f;
  logic [63:0]       r_m;
  logic [15:0]       r_a;
  logic [FIW-1:0]    fe_ra;
  logic [FW-1:0]     fe_rfin;
  logic [15:0]       fe_rx, fe_ry;

  logic [FW:0]       cnt_n;
  logic              slot_ok_n;
  logic [15:0]       dx, dy;
  logic [32:0]       sq_dist;
  logic [FCW:0]      fr_inc;
  logic              live_bit;
  logic signed [HW-1:0] nhigh_n;

  assign r_v = cv_q[ci_q];
  assign r_s = cs_q[ci_q];
  assign r_f = cf_q[ci_q];
  assign r_m = cm_q[ci_q];
  assign r_a = ca_q[ci_q];

  assign fr_inc  = {1'b0, fr_q} + 1'b1;
  assign fe_ra   = (state_q == S_FREE_DEL) ? fr_inc[FIW-1:0] : fr_q[FIW-1:0];
  assign fe_rfin = fe_fin_q[fe_ra];
  assign fe_rx   = fe_x_q[fe_ra];
  assign fe_ry   = fe_y_q[fe_ra];

  assign dx      = (fe_rx > cmd_q.x) ? fe_rx - cmd_q.x : cmd_q.x - fe_rx;
  assign dy      = (fe_ry > cmd_q.y) ? fe_ry - cmd_q.y : cmd_q.y - fe_ry;
  assign sq_dist = 33'(32'(dx) * 32'(dx)) + 33'(32'(dy) * 32'(dy));

  assign al_ra    = {bank_q, ai_q[AIW-1:0]};
  assign al_wa    = {~bank_q, acnt_q[~bank_q][AIW-1:0]};
  assign live_bit = live_q[al_ra];

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    ci_d      = ci_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    slot_ok_d = slot_ok_q;
    fid_d     = fid_q;
    high_d    = high_q;
    nhigh_d   = nhigh_q;
    fr_d      = fr_q;
    wi_d      = wi_q;
    fcnt_d    = fcnt_q;
    best_d    = best_q;
    bestd_d   = bestd_q;
    bestfin_d = bestfin_q;
    bank_d    = bank_q;
    ai_d      = ai_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    nres_d    = nres_q;
    live_d    = live_q;
    acnt_d    = acnt_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o     = pend_q;
    cur_add   = 1'b0;
    cur_upd   = 1'b0;
    cur_clr   = 1'b0;
    fe_wr     = 1'b0;
    fe_wa     = fr_q[FIW-1:0];
    fe_wfin   = fe_rfin;
    fe_wx     = fe_rx;
    fe_wy     = fe_ry;
    al_wr     = 1'b0;
    al_rd_en  = 1'b0;
    cnt_n     = cnt_q;
    slot_ok_n = slot_ok_q;
    nhigh_n   = nhigh_q;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ci_d      = '0;
          cnt_d     = '0;
          slot_ok_d = 1'b0;
          ai_d      = '0;
          nres_d    = '0;
          unique case (cmd_i.action)
            ACT_SET:   state_d = S_SET_SCAN;
            ACT_ALIVE: state_d = S_AL_ADD;
            ACT_END:   state_d = S_END_NEXT;
            default:   state_d = S_IDLE;
          endcase
        end
      end

      S_SET_SCAN: begin
        if (r_v && r_s == cmd_q.sid) begin
          state_d = S_SET_UPD;
        end else begin
          if (r_v) begin
            cnt_n = cnt_q + 1'b1;
          end else if (!slot_ok_q) begin
            slot_d    = ci_q;
            slot_ok_n = 1'b1;
          end
          cnt_d     = cnt_n;
          slot_ok_d = slot_ok_n;
          if (ci_q == FW'(MAX_CURSORS - 1)) begin
            fid_d = FW'(cnt_n);
            if (!slot_ok_n) begin
              state_d = S_IDLE;
            end else if (!high_q[HW-1] && cnt_n <= $unsigned(high_q)) begin
              fr_d    = '0;
              state_d = (fcnt_q != '0) ? S_NEAR : S_ADD;
            end else begin
              high_d  = $signed(cnt_n);
              state_d = S_ADD;
            end
          end else begin
            ci_d = ci_q + 1'b1;
          end
        end
      end

      S_SET_UPD: begin
        if (r_m == {cmd_q.x, cmd_q.y, cmd_q.sx, cmd_q.sy} && r_a == cmd_q.ac) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          cur_upd    = 1'b1;
          res_push_o = 1'b1;
          res_o      = '{ev: EV_UPDATED, sess: r_s, fin: 4'(r_f), x: cmd_q.x,
                         y: cmd_q.y, sx: cmd_q.sx, sy: cmd_q.sy, ac: cmd_q.ac,
                         last: 1'b1};
          state_d    = S_IDLE;
        end
      end

      S_NEAR: begin
        // Nearest free finger, first of equal minima wins
        if (fr_q == fcnt_q) begin
          fid_d   = bestfin_q;
          fr_d    = FCW'(best_q);
          state_d = S_FREE_DEL;
        end else begin
          if (fr_q == '0 || sq_dist < bestd_q) begin
            best_d    = fr_q[FIW-1:0];
            bestd_d   = sq_dist;
            bestfin_d = fe_rfin;
          end
          fr_d = fr_q + 1'b1;
        end
      end

      S_FREE_DEL: begin
        // Close the gap left by the reused entry
        if (fr_inc < {1'b0, fcnt_q}) begin
          fe_wr = 1'b1;
          fr_d  = fr_inc[FCW-1:0];
        end else begin
          fcnt_d  = fcnt_q - 1'b1;
          state_d = S_ADD;
        end
      end

      S_ADD: begin
        if (!res_full_i) begin
          cur_add    = 1'b1;
          res_push_o = 1'b1;
          res_o      = '{ev: EV_ADDED, sess: cmd_q.sid, fin: 4'(fid_q), x: cmd_q.x,
                         y: cmd_q.y, sx: '0, sy: '0, ac: '0, last: 1'b1};
          state_d    = S_IDLE;
        end
      end

      S_AL_ADD: begin
        if (acnt_q[~bank_q] < ACW'(MAX_ALIVE)) begin
          al_wr                 = 1'b1;
          live_d[al_wa]         = 1'b1;
          acnt_d[~bank_q]       = acnt_q[~bank_q] + 1'b1;
        end
        ai_d    = '0;
        state_d = S_AL_SCAN;
      end

      S_AL_SCAN: begin
        if (ai_q == acnt_q[bank_q]) begin
          state_d = S_IDLE;
        end else if (live_bit) begin
          al_rd_en = 1'b1;
          state_d  = S_AL_CMP;
        end else begin
          ai_d = ai_q + 1'b1;
        end
      end

      S_AL_CMP: begin
        if (al_rd_q == cmd_q.sid) begin
          live_d[al_ra] = 1'b0;
          state_d       = S_IDLE;
        end else begin
          ai_d    = ai_q + 1'b1;
          state_d = S_AL_SCAN;
        end
      end

      S_END_NEXT: begin
        if (ai_q == acnt_q[bank_q]) begin
          state_d = S_END_DONE;
        end else if (live_bit) begin
          al_rd_en = 1'b1;
          ci_d     = '0;
          state_d  = S_END_FIND;
        end else begin
          ai_d = ai_q + 1'b1;
        end
      end

      S_END_FIND: begin
        if (r_v && r_s == al_rd_q) begin
          state_d = S_END_REM;
        end else if (ci_q == FW'(MAX_CURSORS - 1)) begin
          ai_d    = ai_q + 1'b1;
          state_d = S_END_NEXT;
        end else begin
          ci_d = ci_q + 1'b1;
        end
      end

      S_END_REM: begin
        // Hold one removal back so the final one can carry last
        if (!(nres_q < NRES_W'(MAX_RESULTS) && pend_v_q && res_full_i)) begin
          if (nres_q < NRES_W'(MAX_RESULTS)) begin
            res_push_o = pend_v_q;
            res_o      = pend_q;
            pend_v_d   = 1'b1;
            pend_d     = '{ev: EV_REMOVED, sess: r_s, fin: 4'(r_f), x: r_m[63:48],
                           y: r_m[47:32], sx: r_m[31:16], sy: r_m[15:0], ac: r_a,
                           last: 1'b0};
            nres_d     = nres_q + 1'b1;
          end
          cur_clr = 1'b1;
          if (!high_q[HW-1] && r_f == high_q[FW-1:0]) begin
            nhigh_d = '1;
            ci_d    = '0;
            state_d = S_HI_SCAN;
          end else begin
            if (!high_q[HW-1] && r_f < high_q[FW-1:0] && fcnt_q < FCW'(MAX_FREE)) begin
              fe_wr   = 1'b1;
              fe_wa   = fcnt_q[FIW-1:0];
              fe_wfin = r_f;
              fe_wx   = r_m[63:48];
              fe_wy   = r_m[47:32];
              fcnt_d  = fcnt_q + 1'b1;
            end
            ai_d    = ai_q + 1'b1;
            state_d = S_END_NEXT;
          end
        end
      end

      S_HI_SCAN: begin
        if (r_v && (nhigh_q[HW-1] || r_f > nhigh_q[FW-1:0])) begin
          nhigh_n = $signed({1'b0, r_f});
        end
        nhigh_d = nhigh_n;
        if (ci_q == FW'(MAX_CURSORS - 1)) begin
          high_d  = nhigh_n;
          fr_d    = '0;
          wi_d    = '0;
          state_d = S_PRUNE;
        end else begin
          ci_d = ci_q + 1'b1;
        end
      end

      S_PRUNE: begin
        if (fr_q == fcnt_q) begin
          fcnt_d  = wi_q;
          ai_d    = ai_q + 1'b1;
          state_d = S_END_NEXT;
        end else begin
          if (!high_q[HW-1] && fe_rfin <= high_q[FW-1:0]) begin
            fe_wr = 1'b1;
            fe_wa = wi_q[FIW-1:0];
            wi_d  = wi_q + 1'b1;
          end
          fr_d = fr_q + 1'b1;
        end
      end

      S_END_DONE: begin
        if (!(pend_v_q && res_full_i)) begin
          res_push_o  = pend_v_q;
          res_o       = pend_q;
          res_o.last  = 1'b1;
          pend_v_d    = 1'b0;
          bank_d      = ~bank_q;
          acnt_d[bank_q] = '0;
          for (int i = 0; i < ALD / 2; i++) begin
            live_d[{bank_q, AIW'(i)}] = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Payload stores
  always_ff @(posedge clk_i) begin
    if (cur_add) begin
      cs_q[slot_q] <= cmd_q.sid;
      cf_q[slot_q] <= fid_q;
      cm_q[slot_q] <= {cmd_q.x, cmd_q.y, 32'd0};
      ca_q[slot_q] <= '0;
    end
    if (cur_upd) begin
      cm_q[ci_q] <= {cmd_q.x, cmd_q.y, cmd_q.sx, cmd_q.sy};
      ca_q[ci_q] <= cmd_q.ac;
    end
    if (fe_wr) begin
      fe_fin_q[fe_wa] <= fe_wfin;
      fe_x_q[fe_wa]   <= fe_wx;
      fe_y_q[fe_wa]   <= fe_wy;
    end
    if (al_wr) begin
      al_mem[al_wa] <= cmd_q.sid;
    end
    if (al_rd_en) begin
      al_rd_q <= al_mem[al_ra];
    end
    cmd_q     <= cmd_d;
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    bestd_q   <= bestd_d;
    bestfin_q <= bestfin_d;
    best_q    <= best_d;
    fid_q     <= fid_d;
    slot_q    <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ci_q      <= '0;
      cnt_q     <= '0;
      slot_ok_q <= 1'b0;
      high_q    <= '1;
      nhigh_q   <= '1;
      fr_q      <= '0;
      wi_q      <= '0;
      fcnt_q    <= '0;
      bank_q    <= 1'b0;
      ai_q      <= '0;
      pend_v_q  <= 1'b0;
      nres_q    <= '0;
      live_q    <= '0;
      acnt_q[0] <= '0;
      acnt_q[1] <= '0;
      for (int i = 0; i < MAX_CURSORS; i++) begin
        cv_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      ci_q      <= ci_d;
      cnt_q     <= cnt_d;
      slot_ok_q <= slot_ok_d;
      high_q    <= high_d;
      nhigh_q   <= nhigh_d;
      fr_q      <= fr_d;
      wi_q      <= wi_d;
      fcnt_q    <= fcnt_d;
      bank_q    <= bank_d;
      ai_q      <= ai_d;
      pend_v_q  <= pend_v_d;
      nres_q    <= nres_d;
      live_q    <= live_d;
      acnt_q    <= acnt_d;
      if (cur_add) begin
        cv_q[slot_q] <= 1'b1;
      end
      if (cur_clr) begin
        cv_q[ci_q] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/touch_cursor_session_tracker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A frame request is absorbed by the front end in its accept cycle. In the back end a set
// request walks the cursor table and, for a new cursor, the free list; an alive id walks
// the alive list; an alive end walks the alive list, the cursor table and the free list,
// all serially. Each request also passes the request queue, each result the result queue.
// Throughput: one request at a time in the back end.
// Reset: asynchronous, active low; clears cursor, free and alive bookkeeping at once.
module touch_cursor_session_tracker_top
  import tcst_pkg::*;
#(
  parameter int unsigned MAX_CURSORS = 16,
  parameter int unsigned MAX_ALIVE   = 32,
  parameter int unsigned MAX_FREE    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        session_id_i,
  input  wire logic signed [31:0] frame_number_i,
  input  wire logic [15:0]        pos_x_i,
  input  wire logic [15:0]        pos_y_i,
  input  wire logic signed [15:0] speed_x_i,
  input  wire logic signed [15:0] speed_y_i,
  input  wire logic signed [15:0] accel_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              event_res_o,
  output logic [31:0]             cursor_session_o,
  output logic [3:0]              finger_id_o,
  output logic [15:0]             out_x_o,
  output logic [15:0]             out_y_o,
  output logic signed [15:0]      out_speed_x_o,
  output logic signed [15:0]      out_speed_y_o,
  output logic signed [15:0]      out_accel_o,
  output logic                    last_o
);

  // Front end -> request queue
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;
  // Back end -> result queue
  logic res_push, res_full;
  res_t res_in, res_out;

  // Front end: frame ordering, stale filtering and request forwarding
  tcst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .action_i      (action_i),
    .session_id_i  (session_id_i),
    .frame_number_i(frame_number_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .speed_x_i     (speed_x_i),
    .speed_y_i     (speed_y_i),
    .accel_i       (accel_i),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  assign full = cmd_full;

  tcst_fifo #(.W($bits(cmd_t)), .D(2)) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_out)
  );

  // Back end: cursor table, free list and alive bookkeeping
  tcst_back #(
    .MAX_CURSORS(MAX_CURSORS),
    .MAX_ALIVE  (MAX_ALIVE),
    .MAX_FREE   (MAX_FREE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  tcst_fifo #(.W($bits(res_t)), .D(2)) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_out)
  );

  // Drive the result ports from the head of the result queue
  assign event_res_o      = res_out.ev;
  assign cursor_session_o = res_out.sess;
  assign finger_id_o      = res_out.fin;
  assign out_x_o          = res_out.x;
  assign out_y_o          = res_out.y;
  assign out_speed_x_o    = res_out.sx;
  assign out_speed_y_o    = res_out.sy;
  assign out_accel_o      = res_out.ac;
  assign last_o           = res_out.last;

endmodule
`default_nettype wire

@@ bench/touch_cursor_session_tracker_top_tb.sv @@
`timescale 1ns / 1ps
module touch_cursor_session_tracker_top_tb;
  import tcst_pkg::*;

  localparam int NCUR  = 16;
  localparam int NALV  = 32;
  localparam int NFREE = 16;
  // worst alive end walk plus slack; used for the final settle and drain pauses
  localparam int SETTLE_CYCLES = 1200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         action_i = '0;
  logic [31:0]        session_id_i = '0;
  logic signed [31:0] frame_number_i = '0;
  logic [15:0]        pos_x_i = '0;
  logic [15:0]        pos_y_i = '0;
  logic signed [15:0] speed_x_i = '0;
  logic signed [15:0] speed_y_i = '0;
  logic signed [15:0] accel_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         event_res_o;
  logic [31:0]        cursor_session_o;
  logic [3:0]         finger_id_o;
  logic [15:0]        out_x_o, out_y_o;
  logic signed [15:0] out_speed_x_o, out_speed_y_o, out_accel_o;
  logic               last_o;

  touch_cursor_session_tracker_top u_top (
    .clk_i, .rst_ni, .push, .full, .action_i, .session_id_i, .frame_number_i,
    .pos_x_i, .pos_y_i, .speed_x_i, .speed_y_i, .accel_i, .empty, .pop,
    .event_res_o, .cursor_session_o, .finger_id_o, .out_x_o, .out_y_o,
    .out_speed_x_o, .out_speed_y_o, .out_accel_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Tracker mirror: cursor table, free finger list, alive sets, frame counters.
  bit        trk_valid[NCUR];
  bit [31:0] trk_sess[NCUR];
  int        trk_fin[NCUR];
  bit [15:0] trk_x[NCUR], trk_y[NCUR], trk_sx[NCUR], trk_sy[NCUR], trk_ac[NCUR];
  int        spare_fin[$];
  bit [15:0] spare_x[$], spare_y[$];
  bit [31:0] prev_alive[$], next_alive[$];
  int        top_finger = -1;
  int        frame_now = -1;
  int        frame_prev = -1;

  res_t      events_due[$];
  int        n_errors = 0;

  function automatic res_t cursor_event(event_e ev, int s);
    res_t r;
    r.ev = ev; r.sess = trk_sess[s]; r.fin = trk_fin[s][3:0];
    r.x = trk_x[s]; r.y = trk_y[s]; r.sx = trk_sx[s]; r.sy = trk_sy[s];
    r.ac = trk_ac[s]; r.last = 1'b0;
    return r;
  endfunction

  function automatic int find_cursor(bit [31:0] sid);
    for (int i = 0; i < NCUR; i++)
      if (trk_valid[i] && trk_sess[i] == sid) return i;
    return -1;
  endfunction

  function automatic void release_finger(int s);
    int f;
    f = trk_fin[s];
    if (f == top_finger) begin
      top_finger = -1;
      for (int i = 0; i < NCUR; i++)
        if (trk_valid[i] && trk_fin[i] > top_finger) top_finger = trk_fin[i];
      // prune free ids above the new highest, keeping order
      for (int i = spare_fin.size() - 1; i >= 0; i--)
        if (spare_fin[i] > top_finger) begin
          spare_fin.delete(i); spare_x.delete(i); spare_y.delete(i);
        end
    end else if (f < top_finger && spare_fin.size() < NFREE) begin
      spare_fin = {spare_fin, f};
      spare_x   = {spare_x, trk_x[s]};
      spare_y   = {spare_y, trk_y[s]};
    end
  endfunction

  // Advance the mirror by one accepted request and queue the events it causes.
  function automatic void track_request(action_e act, bit [31:0] sid, int frame,
                                        bit [15:0] x, bit [15:0] y, bit [15:0] sx,
                                        bit [15:0] sy, bit [15:0] ac);
    bit     stale;
    int     s, cnt, fid, best, n;
    longint unsigned d, bestd, dx, dy;
    res_t   r;
    stale = frame_now < frame_prev && frame_now > 0;
    if (act == ACT_FRAME) begin
      if (frame_now > 0) frame_prev = frame_now;
      frame_now = frame;
      return;
    end
    if (stale) return;
    case (act)
      ACT_SET: begin
        s = find_cursor(sid);
        if (s >= 0) begin
          if (trk_x[s] == x && trk_y[s] == y && trk_sx[s] == sx && trk_sy[s] == sy &&
              trk_ac[s] == ac) return;
          trk_x[s] = x; trk_y[s] = y; trk_sx[s] = sx; trk_sy[s] = sy; trk_ac[s] = ac;
          r = cursor_event(EV_UPDATED, s); r.last = 1'b1;
          events_due = {events_due, r};
          return;
        end
        cnt = 0;
        for (int i = 0; i < NCUR; i++)
          if (trk_valid[i]) cnt++;
          else if (s < 0) s = i;
        if (s < 0) return;
        fid = cnt;
        if (cnt <= top_finger) begin
          if (spare_fin.size() > 0) begin
            best = 0; bestd = 0;
            for (int i = 0; i < spare_fin.size(); i++) begin
              dx = spare_x[i] > x ? spare_x[i] - x : x - spare_x[i];
              dy = spare_y[i] > y ? spare_y[i] - y : y - spare_y[i];
              d = dx * dx + dy * dy;
              if (i == 0 || d < bestd) begin
                best = i; bestd = d;
              end
            end
            fid = spare_fin[best];
            spare_fin.delete(best); spare_x.delete(best); spare_y.delete(best);
          end
        end else begin
          top_finger = fid;
        end
        trk_valid[s] = 1'b1; trk_sess[s] = sid; trk_fin[s] = fid;
        trk_x[s] = x; trk_y[s] = y; trk_sx[s] = '0; trk_sy[s] = '0; trk_ac[s] = '0;
        r = cursor_event(EV_ADDED, s); r.last = 1'b1;
        events_due = {events_due, r};
      end
      ACT_ALIVE: begin
        if (next_alive.size() < NALV) next_alive = {next_alive, sid};
        foreach (prev_alive[i])
          if (prev_alive[i] == sid) begin
            prev_alive.delete(i);
            break;
          end
      end
      default: begin
        n = 0;
        foreach (prev_alive[i]) begin
          s = find_cursor(prev_alive[i]);
          if (s < 0) continue;
          if (n < MAX_RESULTS) begin
            events_due = {events_due, cursor_event(EV_REMOVED, s)};
            n++;
          end
          trk_valid[s] = 1'b0;
          release_finger(s);
        end
        prev_alive = next_alive;
        next_alive = {};
        if (n > 0) events_due[events_due.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // Present one request; hold it until the block takes it, then advance the mirror.
  task automatic send_request(action_e act, bit [31:0] sid, int frame = 0,
                              bit [15:0] x = 0, bit [15:0] y = 0, bit [15:0] sx = 0,
                              bit [15:0] sy = 0, bit [15:0] ac = 0);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= act; session_id_i <= sid; frame_number_i <= frame;
    pos_x_i <= x; pos_y_i <= y; speed_x_i <= sx; speed_y_i <= sy; accel_i <= ac;
    do @(posedge clk_i); while (full);
    track_request(act, sid, frame, x, y, sx, sy, ac);
  endtask

  // Drop push and hold off until every pending event is back and the back end is quiet.
  task automatic drain_events();
    push <= 1'b0;
    @(posedge clk_i);
    while (events_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: random stall per event, check every popped event against the oldest due.
  int pop_hold = 0;
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event ev=%0d sess=%h", $time, event_res_o,
                   cursor_session_o);
          n_errors++;
        end else begin
          want = events_due.pop_front();
          if (event_res_o !== want.ev || cursor_session_o !== want.sess ||
              finger_id_o !== want.fin || out_x_o !== want.x || out_y_o !== want.y ||
              out_speed_x_o !== want.sx || out_speed_y_o !== want.sy ||
              out_accel_o !== want.ac || last_o !== want.last) begin
            $display("%0t: mismatch expected ev=%0d sess=%h fin=%0d x=%h y=%h sx=%h sy=%h ac=%h last=%b",
                     $time, want.ev, want.sess, want.fin, want.x, want.y, want.sx,
                     want.sy, want.ac, want.last);
            $display("%0t:          actual   ev=%0d sess=%h fin=%0d x=%h y=%h sx=%h sy=%h ac=%h last=%b",
                     $time, event_res_o, cursor_session_o, finger_id_o, out_x_o, out_y_o,
                     out_speed_x_o, out_speed_y_o, out_accel_o, last_o);
            n_errors++;
          end
        end
        pop_hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Edge values of every field, each action, repeats, reuse of free fingers.
  task automatic test_directed();
    send_request(ACT_FRAME, 0, 1);
    send_request(ACT_SET, 32'h0000_0000, 0, 16'h0000, 16'h0000);
    send_request(ACT_SET, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_SET, 32'h5A5A_A5A5, 0, 16'h8000, 16'h7FFF);
    // update with extreme motion, then the same values again: no event
    send_request(ACT_SET, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    send_request(ACT_SET, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    send_request(ACT_SET, 32'h0000_0000, 0, 16'h0001, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF);
    // keep only the top finger: lower fingers become free
    send_request(ACT_ALIVE, 32'h0000_0000);
    send_request(ACT_ALIVE, 32'hFFFF_FFFF);
    send_request(ACT_ALIVE, 32'h5A5A_A5A5);
    send_request(ACT_END, 0);
    send_request(ACT_ALIVE, 32'h5A5A_A5A5);
    send_request(ACT_ALIVE, 32'h1234_5678);
    send_request(ACT_END, 0);
    // a new cursor takes the nearest free finger
    send_request(ACT_SET, 32'h1111_1111, 0, 16'hFFF0, 16'h0010);
    // stale frame: drop set and end
    send_request(ACT_FRAME, 0, 32'h7FFF_FFFF);
    send_request(ACT_FRAME, 0, 5);
    send_request(ACT_SET, 32'h2222_2222, 0, 16'h1234, 16'h4321);
    send_request(ACT_END, 0);
    send_request(ACT_FRAME, 0, 32'h8000_0000);
    send_request(ACT_FRAME, 0, 6);
    // remove the cursors on the alive list, releasing the highest finger and pruning the free list
    send_request(ACT_END, 0);
    send_request(ACT_END, 0);
    drain_events();
  endtask

  // Overflow the alive set and the cursor table, then remove all cursors on the alive list at once.
  task automatic test_overflow();
    for (int i = 0; i < NCUR + 3; i++)
      send_request(ACT_SET, 32'hC000_0000 + i, 0, 16'($urandom), 16'($urandom));
    for (int i = 0; i < NALV + 3; i++) send_request(ACT_ALIVE, 32'hC000_0000 + i);
    send_request(ACT_END, 0);
    send_request(ACT_END, 0);
    drain_events();
  endtask

  // Frames of random content over a small id pool so ids recur.
  task automatic test_random_frames();
    bit [31:0] pool[24];
    int        frame;
    int        pick;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    frame = 10;
    for (int f = 0; f < 7; f++) begin
      frame += $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) send_request(ACT_FRAME, 0, $urandom);
      send_request(ACT_FRAME, 0, frame);
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 23);
        if ($urandom_range(0, 3) == 0)
          send_request(ACT_SET, pool[pick], 0, 16'h0100, 16'h0200, 16'h0010, 16'hFFF0, 16'h0001);
        else
          send_request(ACT_SET, pool[pick], 0, 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
      end
      foreach (pool[i])
        if ($urandom_range(0, 9) < 6) send_request(ACT_ALIVE, pool[i]);
      if ($urandom_range(0, 5) == 0) send_request(ACT_ALIVE, $urandom);
      send_request(ACT_END, 0);
      if (f == 3) drain_events();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random_frames();
    drain_events();
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
